[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Each macro expects clk_i and rst_ni in the scope of the module that uses it.

`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");

`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/tlrqs_pkg.sv]
package tlrqs_pkg;

  localparam int NumProcs  = 32;
  localparam int ProcW     = 5;
  localparam int PidW      = $clog2(NumProcs);
  localparam int PtrW      = PidW + 1;
  localparam int NumQueues = 3;

  localparam logic [PtrW-1:0] QNull = PtrW'(NumProcs);

  localparam logic [1:0] ClsTask   = 2'd0;
  localparam logic [1:0] ClsServer = 2'd1;
  localparam logic [1:0] ClsUser   = 2'd2;

  typedef enum logic [1:0] {
    OP_READY,
    OP_UNREADY,
    OP_ROTATE,
    OP_STOP
  } op_e;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_ENQ_USER,
    ACT_APP_CLEAR,
    ACT_APP_LINK,
    ACT_WALK,
    ACT_UNLINK,
    ACT_UNMARK,
    ACT_ROT_MOVE,
    ACT_ROT_CLEAR,
    ACT_STOP,
    ACT_PICK
  } act_e;

  typedef struct packed {
    act_e act;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic user_cls;
    logic ign;
    logic walk_hit;
    logic walk_end;
    logic rot_ok;
  } sts_t;

  function automatic logic is_proc(input logic [PtrW-1:0] ptr);
    return ptr < QNull;
  endfunction

endpackage

[hdl/three_level_ready_queue_scheduler.sv]
// Keeps three linked ready queues of process numbers (task, server, user, in falling
// priority) and answers every operation word with one result word: the process to run,
// the billed process and whether the operation was ignored. A make not ready that is not
// ignored walks the owning queue one link per cycle through the single read port of the
// link memory, so its time grows with the number of entries ahead of the removed process.
// One operation is in flight at a time; the next word is taken while the previous result
// still waits in the output register.
module three_level_ready_queue_scheduler
  import tlrqs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // op[1:0], proc_id[6:2], proc_class[8:7], zero[15:9]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // current_proc[4:0], run_idle[5], billed_proc[10:6],
                                     // billed_idle[11], status[12], zero[15:13]
);

  cmd_t             cmd;
  sts_t             sts;
  logic [ProcW-1:0] current_proc, billed_proc;
  logic             run_idle, billed_idle, status;

  tlrqs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tlrqs_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (s_axis_tdata[1:0]),
    .proc_id_i      (s_axis_tdata[6:2]),
    .proc_class_i   (s_axis_tdata[8:7]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .current_proc_o (current_proc),
    .run_idle_o     (run_idle),
    .billed_proc_o  (billed_proc),
    .billed_idle_o  (billed_idle),
    .status_o       (status)
  );

  assign m_axis_tdata = {3'b000, status, billed_idle, billed_proc, run_idle, current_proc};

endmodule

[hdl/tlrqs_ctrl.sv]
`include "assert_macros.svh"

module tlrqs_ctrl
  import tlrqs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_valid_i,
  output logic s_ready_o,
  output logic m_valid_o,
  input  logic m_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_APP_LINK,
    S_WALK,
    S_UNLINK,
    S_ROT_MOVE,
    S_ROT_CLEAR,
    S_PICK
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  act_e   act;

  always_comb begin
    state_d     = state_q;
    act         = ACT_NONE;
    out_valid_d = out_valid_q && !m_ready_i;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          act     = ACT_LOAD;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.ign) begin
          state_d = S_PICK;
        end else begin
          case (sts_i.op)
            OP_READY: begin
              if (sts_i.user_cls) begin
                act     = ACT_ENQ_USER;
                state_d = S_PICK;
              end else begin
                act     = ACT_APP_CLEAR;
                state_d = S_APP_LINK;
              end
            end
            OP_UNREADY: state_d = S_WALK;
            OP_ROTATE:  state_d = S_ROT_MOVE;
            default: begin
              act     = ACT_STOP;
              state_d = S_PICK;
            end
          endcase
        end
      end
      S_APP_LINK: begin
        act     = ACT_APP_LINK;
        state_d = S_PICK;
      end
      S_WALK: begin
        if (sts_i.walk_hit) begin
          state_d = S_UNLINK;
        end else if (sts_i.walk_end) begin
          act     = ACT_UNMARK;
          state_d = S_PICK;
        end else begin
          act = ACT_WALK;
        end
      end
      S_UNLINK: begin
        act     = ACT_UNLINK;
        state_d = S_PICK;
      end
      S_ROT_MOVE: begin
        if (sts_i.rot_ok) begin
          act     = ACT_ROT_MOVE;
          state_d = S_ROT_CLEAR;
        end else begin
          state_d = S_PICK;
        end
      end
      S_ROT_CLEAR: begin
        act     = ACT_ROT_CLEAR;
        state_d = S_PICK;
      end
      S_PICK: begin
        if (!out_valid_q || m_ready_i) begin
          act         = ACT_PICK;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_ready_o  = (state_q == S_IDLE);
  assign m_valid_o  = out_valid_q;
  assign cmd_o.act  = act;

  `ASSERT_IMP(a_pick_has_room, act == ACT_PICK, !out_valid_q || m_ready_i)
  `ASSERT_NEXT(a_ignored_skips_work, state_q == S_DISPATCH && sts_i.ign, state_q == S_PICK)
  `ASSERT_IMP(a_walk_only_unready, state_q == S_WALK, sts_i.op == OP_UNREADY)

endmodule

[hdl/tlrqs_datapath.sv]
`include "assert_macros.svh"

module tlrqs_datapath
  import tlrqs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       op_i,
  input  logic [ProcW-1:0] proc_id_i,
  input  logic [1:0]       proc_class_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output logic [ProcW-1:0] current_proc_o,
  output logic             run_idle_o,
  output logic [ProcW-1:0] billed_proc_o,
  output logic             billed_idle_o,
  output logic             status_o
);

  logic [PtrW-1:0] link_mem [NumProcs];
  logic [PtrW-1:0] rd_data_q;

  op_e             op_q;
  logic [PtrW-1:0] pid_q;
  logic [1:0]      cls_q;
  logic            ign_q;
  logic            first_q;
  logic [PtrW-1:0] prev_q;
  logic [PtrW-1:0] head_q [NumQueues];
  logic [PtrW-1:0] tail_q [NumQueues];
  logic [NumProcs-1:0] mark_q;
  logic [1:0]      ecls_q [NumProcs];
  logic [PtrW-1:0] billed_q, billed_d;

  logic [ProcW-1:0] cur_proc_q, billed_proc_q;
  logic             run_idle_q, billed_idle_q, status_q;

  logic [PidW-1:0] pid_idx;
  logic [PtrW-1:0] pin;
  logic            pin_ok, pin_mark, ign_in;
  logic [1:0]      qsel;
  logic            qsel_ok;
  logic [PtrW-1:0] head_sel, tail_sel, cur, rd_addr, new_head, chosen;
  logic            wr_en;
  logic [PtrW-1:0] wr_addr, wr_data;

  assign pid_idx  = pid_q[PidW-1:0];
  assign pin      = PtrW'(proc_id_i);
  assign pin_ok   = is_proc(pin);
  assign pin_mark = mark_q[pin[PidW-1:0]];

  always_comb begin
    case (op_e'(op_i))
      OP_READY:   ign_in = !pin_ok || (proc_class_i > ClsUser) || pin_mark;
      OP_UNREADY: ign_in = !pin_ok || !pin_mark;
      default:    ign_in = 1'b0;
    endcase
  end

  always_comb begin
    case (op_q)
      OP_READY:   qsel = cls_q;
      OP_UNREADY: qsel = ecls_q[pid_idx];
      default:    qsel = ClsUser;
    endcase
  end

  assign qsel_ok  = qsel <= ClsUser;
  assign head_sel = qsel_ok ? head_q[qsel] : QNull;
  assign tail_sel = qsel_ok ? tail_q[qsel] : QNull;
  assign cur      = first_q ? head_sel : rd_data_q;
  assign rd_addr  = (op_q == OP_ROTATE) ? head_q[ClsUser] : cur;
  assign new_head = is_proc(prev_q) ? head_sel : rd_data_q;

  assign sts_o.op       = op_q;
  assign sts_o.user_cls = (cls_q == ClsUser);
  assign sts_o.ign      = ign_q;
  assign sts_o.walk_hit = (cur == pid_q);
  assign sts_o.walk_end = !is_proc(cur);
  assign sts_o.rot_ok   = is_proc(head_q[ClsUser]) && is_proc(tail_q[ClsUser]) &&
                          is_proc(rd_data_q);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pid_q;
    wr_data = QNull;
    case (cmd_i.act)
      ACT_ENQ_USER: begin
        wr_en   = 1'b1;
        wr_data = head_q[ClsUser];
      end
      ACT_APP_CLEAR: begin
        wr_en = 1'b1;
      end
      ACT_APP_LINK: begin
        wr_en   = is_proc(head_sel) && is_proc(tail_sel);
        wr_addr = tail_sel;
        wr_data = pid_q;
      end
      ACT_UNLINK: begin
        wr_en   = is_proc(prev_q);
        wr_addr = prev_q;
        wr_data = rd_data_q;
      end
      ACT_ROT_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = tail_q[ClsUser];
        wr_data = head_q[ClsUser];
      end
      ACT_ROT_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = prev_q;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      link_mem[wr_addr[PidW-1:0]] <= wr_data;
    end
    rd_data_q <= link_mem[rd_addr[PidW-1:0]];
  end

  always_comb begin
    billed_d = billed_q;
    if (is_proc(head_q[ClsTask])) begin
      chosen = head_q[ClsTask];
    end else if (is_proc(head_q[ClsServer])) begin
      chosen = head_q[ClsServer];
    end else if (is_proc(head_q[ClsUser])) begin
      chosen   = head_q[ClsUser];
      billed_d = head_q[ClsUser];
    end else begin
      chosen   = QNull;
      billed_d = QNull;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= OP_READY;
      first_q  <= 1'b0;
      mark_q   <= '0;
      billed_q <= QNull;
      for (int i = 0; i < NumQueues; i++) begin
        head_q[i] <= QNull;
        tail_q[i] <= QNull;
      end
    end else begin
      case (cmd_i.act)
        ACT_LOAD: begin
          op_q    <= op_e'(op_i);
          first_q <= 1'b1;
        end
        ACT_ENQ_USER: begin
          if (!is_proc(head_q[ClsUser])) begin
            tail_q[ClsUser] <= pid_q;
          end
          head_q[ClsUser] <= pid_q;
          mark_q[pid_idx] <= 1'b1;
        end
        ACT_APP_CLEAR: begin
          mark_q[pid_idx] <= 1'b1;
        end
        ACT_APP_LINK: begin
          if (!(is_proc(head_sel) && is_proc(tail_sel))) begin
            head_q[qsel] <= pid_q;
          end
          tail_q[qsel] <= pid_q;
        end
        ACT_WALK: begin
          first_q <= 1'b0;
        end
        ACT_UNLINK: begin
          if (!is_proc(prev_q)) begin
            head_q[qsel] <= rd_data_q;
          end
          if (!is_proc(new_head)) begin
            tail_q[qsel] <= QNull;
          end else if (tail_sel == pid_q) begin
            tail_q[qsel] <= prev_q;
          end
          mark_q[pid_idx] <= 1'b0;
        end
        ACT_UNMARK: begin
          mark_q[pid_idx] <= 1'b0;
        end
        ACT_ROT_MOVE: begin
          head_q[ClsUser] <= rd_data_q;
          tail_q[ClsUser] <= head_q[ClsUser];
        end
        ACT_STOP: begin
          for (int i = 0; i < NumProcs; i++) begin
            if (mark_q[i] && ecls_q[i] == ClsUser) begin
              mark_q[i] <= 1'b0;
            end
          end
          head_q[ClsUser] <= QNull;
          tail_q[ClsUser] <= QNull;
        end
        ACT_PICK: begin
          billed_q <= billed_d;
        end
        default: first_q <= first_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.act)
      ACT_LOAD: begin
        pid_q  <= pin;
        cls_q  <= proc_class_i;
        ign_q  <= ign_in;
        prev_q <= QNull;
      end
      ACT_ENQ_USER:  ecls_q[pid_idx] <= ClsUser;
      ACT_APP_CLEAR: ecls_q[pid_idx] <= cls_q;
      ACT_WALK:      prev_q <= cur;
      ACT_ROT_MOVE:  prev_q <= head_q[ClsUser];
      ACT_PICK: begin
        cur_proc_q    <= is_proc(chosen) ? ProcW'(chosen) : '0;
        run_idle_q    <= !is_proc(chosen);
        billed_proc_q <= is_proc(billed_d) ? ProcW'(billed_d) : '0;
        billed_idle_q <= !is_proc(billed_d);
        status_q      <= ign_q;
      end
      default: prev_q <= prev_q;
    endcase
  end

  assign current_proc_o = cur_proc_q;
  assign run_idle_o     = run_idle_q;
  assign billed_proc_o  = billed_proc_q;
  assign billed_idle_o  = billed_idle_q;
  assign status_o       = status_q;

  `ASSERT_ALWAYS(a_task_ends_agree, (head_q[ClsTask] == QNull) == (tail_q[ClsTask] == QNull))
  `ASSERT_ALWAYS(a_user_ends_agree, (head_q[ClsUser] == QNull) == (tail_q[ClsUser] == QNull))
  `ASSERT_IMP(a_user_head_marked, is_proc(head_q[ClsUser]), mark_q[head_q[ClsUser][PidW-1:0]])

endmodule

[tb/sv/three_level_ready_queue_scheduler_tb.sv]
module three_level_ready_queue_scheduler_tb;
  import tlrqs_pkg::*;

  typedef struct packed {
    logic             ignored;
    logic             bill_idle;
    logic [ProcW-1:0] bill;
    logic             idle;
    logic [ProcW-1:0] cur;
  } pick_t;

  class sched_checker;
    logic [PtrW-1:0] next_link [NumProcs];
    bit              in_queue  [NumProcs];
    logic [1:0]      owner_cls [NumProcs];
    logic [PtrW-1:0] head      [NumQueues];
    logic [PtrW-1:0] tail      [NumQueues];
    logic [PtrW-1:0] billed;
    pick_t           pending_picks [$];
    int              errors;
    int              op_count [4];
    int              ignored;
    int              picks_checked;

    function new();
      foreach (in_queue[i]) begin
        in_queue[i]  = 1'b0;
        next_link[i] = QNull;
        owner_cls[i] = ClsTask;
      end
      foreach (head[c]) begin
        head[c] = QNull;
        tail[c] = QNull;
      end
      foreach (op_count[i]) op_count[i] = 0;
      billed        = QNull;
      errors        = 0;
      ignored       = 0;
      picks_checked = 0;
    endfunction

    function bit is_entry(logic [PtrW-1:0] ptr);
      return ptr < QNull;
    endfunction

    function void join_queue(logic [PidW-1:0] p, logic [1:0] c);
      if (c == ClsUser) begin
        next_link[p] = head[c];
        if (!is_entry(head[c])) tail[c] = PtrW'(p);
        head[c] = PtrW'(p);
      end else begin
        next_link[p] = QNull;
        if (is_entry(head[c]) && is_entry(tail[c])) next_link[tail[c][PidW-1:0]] = PtrW'(p);
        else head[c] = PtrW'(p);
        tail[c] = PtrW'(p);
      end
      owner_cls[p] = c;
      in_queue[p]  = 1'b1;
    endfunction

    // The predecessor is located first so that its link can bypass the leaving entry.
    function void leave_queue(logic [PidW-1:0] p);
      logic [1:0]      c;
      logic [PtrW-1:0] prev;
      logic [PtrW-1:0] cur;
      c    = owner_cls[p];
      prev = QNull;
      cur  = head[c];
      for (int i = 0; i < NumProcs && is_entry(cur); i++) begin
        if (cur == PtrW'(p)) break;
        prev = cur;
        cur  = next_link[cur[PidW-1:0]];
      end
      if (cur == PtrW'(p)) begin
        if (is_entry(prev)) next_link[prev[PidW-1:0]] = next_link[p];
        else head[c] = next_link[p];
        if (tail[c] == PtrW'(p)) tail[c] = prev;
        if (!is_entry(head[c])) tail[c] = QNull;
      end
      in_queue[p] = 1'b0;
    endfunction

    function void rotate_user();
      logic [PtrW-1:0] h;
      logic [PtrW-1:0] t;
      h = head[ClsUser];
      t = tail[ClsUser];
      if (!is_entry(h) || !is_entry(t) || !is_entry(next_link[h[PidW-1:0]])) return;
      head[ClsUser]          = next_link[h[PidW-1:0]];
      next_link[h[PidW-1:0]] = QNull;
      next_link[t[PidW-1:0]] = h;
      tail[ClsUser]          = h;
    endfunction

    function void stop_user();
      foreach (in_queue[i])
        if (in_queue[i] && owner_cls[i] == ClsUser) in_queue[i] = 1'b0;
      head[ClsUser] = QNull;
      tail[ClsUser] = QNull;
    endfunction

    function void note_op(op_e op, logic [PidW-1:0] p, logic [1:0] c);
      pick_t           want;
      logic [PtrW-1:0] chosen;
      want.ignored = 1'b0;
      case (op)
        OP_READY: begin
          if (c > ClsUser || in_queue[p]) want.ignored = 1'b1;
          else join_queue(p, c);
        end
        OP_UNREADY: begin
          if (!in_queue[p]) want.ignored = 1'b1;
          else leave_queue(p);
        end
        OP_ROTATE: rotate_user();
        default:   stop_user();
      endcase
      chosen = QNull;
      for (int q = 0; q < NumQueues; q++) begin
        if (is_entry(head[q])) begin
          chosen = head[q];
          if (q == ClsUser) billed = chosen;
          break;
        end
      end
      if (!is_entry(chosen)) billed = QNull;
      want.idle      = !is_entry(chosen);
      want.cur       = want.idle ? '0 : chosen[ProcW-1:0];
      want.bill_idle = !is_entry(billed);
      want.bill      = want.bill_idle ? '0 : billed[ProcW-1:0];
      pending_picks.push_back(want);
      op_count[op]++;
      if (want.ignored) ignored++;
    endfunction

    function void compare(string what, int want_v, int got_v);
      if (want_v != got_v) begin
        $display("%0t: %s expected %0d actual %0d", $time, what, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_word(logic [15:0] w);
      pick_t got;
      pick_t want;
      got = pick_t'(w[12:0]);
      picks_checked++;
      if (pending_picks.size() == 0) begin
        $display("%0t: result word %h arrived with none expected", $time, w);
        errors++;
        return;
      end
      want = pending_picks.pop_front();
      compare("current_proc", want.cur, got.cur);
      compare("run_idle", want.idle, got.idle);
      compare("billed_proc", want.bill, got.bill);
      compare("billed_idle", want.bill_idle, got.bill_idle);
      compare("status", want.ignored, got.ignored);
      compare("zero fill", 0, w[15:13]);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;

  int src_idle_pct;
  int dst_idle_pct;

  sched_checker sb = new();

  three_level_ready_queue_scheduler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("three_level_ready_queue_scheduler_tb: FAIL");
    $finish;
  end

  task automatic send_word(op_e op, logic [4:0] id, logic [1:0] cls);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, cls, id, op};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_op(op, id, cls);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
  endtask

  function automatic logic [4:0] find_proc(bit queued);
    int start;
    start = $urandom_range(NumProcs - 1);
    for (int k = 0; k < NumProcs; k++)
      if (sb.in_queue[(start + k) % NumProcs] == queued) return 5'((start + k) % NumProcs);
    return 5'(start);
  endfunction

  // Mostly well-formed traffic so the queues grow deep, with some raw noise mixed in.
  task automatic run_random(int n);
    int         r;
    logic [4:0] id;
    logic [1:0] cls;
    op_e        op;
    for (int k = 0; k < n; k++) begin
      r   = $urandom_range(99);
      id  = 5'($urandom_range(31));
      cls = 2'($urandom_range(3));
      if (r < 6) begin
        op = op_e'($urandom_range(3));
      end else if (r < 48) begin
        op  = OP_READY;
        id  = find_proc(1'b0);
        cls = 2'($urandom_range(2));
      end else if (r < 78) begin
        op = OP_UNREADY;
        id = find_proc(1'b1);
      end else if (r < 96) begin
        op = OP_ROTATE;
      end else begin
        op = OP_STOP;
      end
      send_word(op, id, cls);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
  end

  // The receiver stalls once for a long stretch so that the block backs up into its input.
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && sb.picks_checked >= 850) begin
        held      = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    src_idle_pct = 15;
    dst_idle_pct = 87;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(OP_ROTATE, 5'd0, ClsTask);
    send_word(OP_STOP, 5'd31, 2'd3);
    send_word(OP_UNREADY, 5'd0, ClsTask);
    send_word(OP_READY, 5'd31, 2'd3);
    send_word(OP_READY, 5'd5, ClsUser);
    send_word(OP_READY, 5'd9, ClsUser);
    send_word(OP_READY, 5'd31, ClsUser);
    send_word(OP_ROTATE, 5'd0, ClsTask);
    send_word(OP_READY, 5'd0, ClsTask);
    send_word(OP_READY, 5'd0, ClsServer);
    send_word(OP_READY, 5'd17, ClsServer);
    send_word(OP_READY, 5'd20, ClsTask);
    send_word(OP_UNREADY, 5'd20, ClsUser);
    send_word(OP_UNREADY, 5'd0, ClsServer);
    send_word(OP_UNREADY, 5'd17, ClsTask);
    send_word(OP_UNREADY, 5'd5, ClsTask);
    send_word(OP_ROTATE, 5'd31, 2'd3);
    send_word(OP_UNREADY, 5'd9, ClsTask);
    send_word(OP_ROTATE, 5'd0, ClsTask);
    send_word(OP_READY, 5'd10, ClsUser);
    send_word(OP_READY, 5'd21, ClsServer);
    send_word(OP_STOP, 5'd0, ClsTask);
    send_word(OP_UNREADY, 5'd21, ClsServer);
    send_word(OP_UNREADY, 5'd31, ClsUser);
    send_word(OP_READY, 5'd30, ClsTask);

    run_random(384);
    src_idle_pct = 87;
    dst_idle_pct = 15;
    run_random(384);
    src_idle_pct = 0;
    dst_idle_pct = 0;
    run_random(382);
    s_axis_tvalid <= 1'b0;

    while (sb.pending_picks.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Covered %0d ready, %0d not-ready, %0d rotate and %0d stop words, %0d ignored.",
             sb.op_count[OP_READY], sb.op_count[OP_UNREADY], sb.op_count[OP_ROTATE],
             sb.op_count[OP_STOP], sb.ignored);
    $display("Checked %0d result words with %0d field mismatches.", sb.picks_checked, sb.errors);
    if (sb.errors == 0 && sb.pending_picks.size() == 0) begin
      $display("three_level_ready_queue_scheduler_tb: PASS");
    end else begin
      $display("three_level_ready_queue_scheduler_tb: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/tlrqs_pkg.sv
hdl/tlrqs_ctrl.sv
hdl/tlrqs_datapath.sv
hdl/three_level_ready_queue_scheduler.sv
tb/sv/three_level_ready_queue_scheduler_tb.sv
